[sv/sata_dma_read_command_builder_assert.svh]
// assertion macros for the sata dma read command builder
// expects clk and rst_n in the scope where a macro is used
`ifndef SATA_DMA_READ_COMMAND_BUILDER_ASSERT_SVH
`define SATA_DMA_READ_COMMAND_BUILDER_ASSERT_SVH
`ifndef SYNTHESIS
`define SDRCB_ASSERT_SAME(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("sdrcb same-cycle assertion failed");
`define SDRCB_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("sdrcb next-cycle assertion failed");
`else
`define SDRCB_ASSERT_SAME(label, cond, prop)
`define SDRCB_ASSERT_NEXT(label, cond, prop)
`endif
`endif

[sv/sdrcb_pkg.sv]
// shared constants, status codes and the command type of the read command builder
// no dependencies
package sdrcb_pkg;

    localparam int SLOTS         = 32;
    localparam int SLOT_W        = 5;
    localparam int SLOT_COUNT_W  = 6;
    localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RESET = 6'd32;

    localparam int LBA_W         = 48;
    localparam int COUNT_W       = 17;
    localparam int ADDR_W        = 32;
    localparam int BYTES_W       = 22;
    localparam int FIS_COUNT_W   = 16;
    localparam int IDX_W         = 3;
    localparam int TLEN_W        = 4;
    localparam int STATUS_W      = 2;

    localparam int COUNT_LIMIT   = 65536;
    localparam int BLOCK_SHIFT   = 9;                          // 512-byte blocks
    localparam int ENTRY_SHIFT   = 22;                         // 4 MiB entries
    localparam int TAIL_W        = ENTRY_SHIFT - BLOCK_SHIFT;  // blocks within one entry

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LARGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOSLOT = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [SLOT_W-1:0]      slot;
        logic [IDX_W-1:0]       entries_m1;
        logic [TAIL_W-1:0]      tail_blocks_m1;
        logic [ADDR_W-1:0]      buffer_address;
        logic [LBA_W-1:0]       lba;
        logic [FIS_COUNT_W-1:0] fis_count;
    } cmd_t;

endpackage

[sv/sdrcb_front.sv]
// front end: slot count register, request checks and lowest free slot search
// depends on sdrcb_pkg
module sdrcb_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_enable,
    input  logic [sdrcb_pkg::SLOT_COUNT_W-1:0] cfg_write_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sdrcb_pkg::LBA_W-1:0]       start_lba,
    input  logic [sdrcb_pkg::COUNT_W-1:0]     block_count,
    input  logic [sdrcb_pkg::ADDR_W-1:0]      buffer_address,
    input  logic [sdrcb_pkg::SLOTS-1:0]       active_slots,
    input  logic [sdrcb_pkg::SLOTS-1:0]       issued_slots,
    input  logic                              queue_full,
    output logic                              push,
    output sdrcb_pkg::cmd_t                   cmd
);
    import sdrcb_pkg::*;

    logic [SLOT_COUNT_W-1:0] slot_count_reg;
    logic [SLOT_COUNT_W-1:0] slot_count_next;
    logic [SLOTS-1:0]        slot_mask;
    logic [SLOTS-1:0]        free_slots;
    logic [SLOTS-1:0]        lowest_free;
    logic [SLOT_W-1:0]       slot_sel;
    logic                    slot_found;
    logic [COUNT_W-1:0]      count_m1;
    logic                    too_large;

    assign slot_count_next = cfg_write_enable ? cfg_write_data : slot_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SLOT_COUNT_RESET;
        end
        else
        begin
            slot_count_reg <= slot_count_next;
        end
    end

    // slots beyond the configured count are never free
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_mask[i] = (SLOT_COUNT_W'(i) < slot_count_reg);
        end
    end

    assign free_slots  = ~(active_slots | issued_slots) & slot_mask;
    assign lowest_free = free_slots & (~free_slots + 1'b1);
    assign slot_found  = |free_slots;

    always_comb
    begin
        slot_sel = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_sel = slot_sel | (lowest_free[i] ? SLOT_W'(i) : '0);
        end
    end

    assign count_m1  = block_count - COUNT_W'(1);
    assign too_large = block_count > COUNT_W'(COUNT_LIMIT);

    always_comb
    begin
        cmd = '0;
        if (block_count == '0)
        begin
            cmd.status = ST_ZERO;
        end
        else if (too_large)
        begin
            cmd.status = ST_LARGE;
        end
        else if (!slot_found)
        begin
            cmd.status = ST_NOSLOT;
        end
        else
        begin
            cmd.status         = ST_OK;
            cmd.slot           = slot_sel;
            cmd.entries_m1     = count_m1[TAIL_W +: IDX_W];
            cmd.tail_blocks_m1 = count_m1[TAIL_W-1:0];
            cmd.buffer_address = buffer_address;
            cmd.lba            = start_lba;
            cmd.fis_count      = block_count[FIS_COUNT_W-1:0];
        end
    end

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

endmodule

[sv/sdrcb_fifo.sv]
// short command queue between the front and back ends
// depends on sdrcb_pkg
module sdrcb_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sdrcb_pkg::cmd_t push_cmd,
    input  logic            pop,
    output sdrcb_pkg::cmd_t head_cmd,
    output logic            full,
    output logic            empty
);
    import sdrcb_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   fill_reg;
    logic [QPTR_W:0]   fill_next;

    assign full     = fill_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty    = fill_reg == '0;
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[sv/sdrcb_back.sv]
// back end: walks the descriptor entries of the head command into an output register
// depends on sdrcb_pkg
module sdrcb_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sdrcb_pkg::cmd_t                     head_cmd,
    input  logic                                empty,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sdrcb_pkg::STATUS_W-1:0]      status,
    output logic [sdrcb_pkg::SLOT_W-1:0]        slot,
    output logic [sdrcb_pkg::TLEN_W-1:0]        table_length,
    output logic [sdrcb_pkg::IDX_W-1:0]         entry_index,
    output logic [sdrcb_pkg::ADDR_W-1:0]        entry_address,
    output logic [sdrcb_pkg::BYTES_W-1:0]       entry_bytes_minus_one,
    output logic [sdrcb_pkg::LBA_W-1:0]         fis_lba,
    output logic [sdrcb_pkg::FIS_COUNT_W-1:0]   fis_count,
    output logic                                last
);
    import sdrcb_pkg::*;

    logic                   load;
    logic                   is_err;
    logic                   is_last;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic [STATUS_W-1:0]    status_reg,  status_next;
    logic [SLOT_W-1:0]      slot_reg,    slot_next;
    logic [TLEN_W-1:0]      tlen_reg,    tlen_next;
    logic [IDX_W-1:0]       eidx_reg,    eidx_next;
    logic [ADDR_W-1:0]      addr_reg,    addr_next;
    logic [BYTES_W-1:0]     bytes_reg,   bytes_next;
    logic [LBA_W-1:0]       lba_reg,     lba_next;
    logic [FIS_COUNT_W-1:0] fcount_reg,  fcount_next;
    logic                   last_reg,    last_next;

    assign load    = !empty && (!valid_reg || out_ready);
    assign is_err  = head_cmd.status != ST_OK;
    assign is_last = is_err || (idx_reg == head_cmd.entries_m1);
    assign pop     = load && is_last;

    assign idx_next   = load ? (is_last ? '0 : idx_reg + 1'b1) : idx_reg;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_comb
    begin
        status_next = head_cmd.status;
        slot_next   = '0;
        tlen_next   = '0;
        eidx_next   = '0;
        addr_next   = '0;
        bytes_next  = '0;
        lba_next    = '0;
        fcount_next = '0;
        last_next   = is_last;
        if (!is_err)
        begin
            slot_next   = head_cmd.slot;
            tlen_next   = TLEN_W'(head_cmd.entries_m1) + TLEN_W'(1);
            eidx_next   = idx_reg;
            // every earlier entry is full, so the offset is index times 4 MiB
            addr_next   = head_cmd.buffer_address + (ADDR_W'(idx_reg) << ENTRY_SHIFT);
            bytes_next  = is_last ? {head_cmd.tail_blocks_m1, {BLOCK_SHIFT{1'b1}}} : '1;
            lba_next    = head_cmd.lba;
            fcount_next = head_cmd.fis_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            tlen_reg   <= tlen_next;
            eidx_reg   <= eidx_next;
            addr_reg   <= addr_next;
            bytes_reg  <= bytes_next;
            lba_reg    <= lba_next;
            fcount_reg <= fcount_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid             = valid_reg;
    assign status                = status_reg;
    assign slot                  = slot_reg;
    assign table_length          = tlen_reg;
    assign entry_index           = eidx_reg;
    assign entry_address         = addr_reg;
    assign entry_bytes_minus_one = bytes_reg;
    assign fis_lba               = lba_reg;
    assign fis_count             = fcount_reg;
    assign last                  = last_reg;

endmodule

[sv/sata_dma_read_command_builder.sv]
// path: with the queue empty, an accepted request item is written into the command queue, and
// its first result item is then registered in the output register of the back end
// throughput: one result per cycle while out_ready is high; a request yields table_length
// entries (1 to 8) in the entry walker of the back end, or a single item for an error; the
// front takes an item per cycle while the two-deep command queue has room
// reset: asynchronous active low, empties the queue, drops out_valid, slot_count to 32
`include "sata_dma_read_command_builder_assert.svh"
module sata_dma_read_command_builder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_enable,
    input  logic [sdrcb_pkg::SLOT_COUNT_W-1:0]  cfg_write_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sdrcb_pkg::LBA_W-1:0]         start_lba,
    input  logic [sdrcb_pkg::COUNT_W-1:0]       block_count,
    input  logic [sdrcb_pkg::ADDR_W-1:0]        buffer_address,
    input  logic [sdrcb_pkg::SLOTS-1:0]         active_slots,
    input  logic [sdrcb_pkg::SLOTS-1:0]         issued_slots,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sdrcb_pkg::STATUS_W-1:0]      status,
    output logic [sdrcb_pkg::SLOT_W-1:0]        slot,
    output logic [sdrcb_pkg::TLEN_W-1:0]        table_length,
    output logic [sdrcb_pkg::IDX_W-1:0]         entry_index,
    output logic [sdrcb_pkg::ADDR_W-1:0]        entry_address,
    output logic [sdrcb_pkg::BYTES_W-1:0]       entry_bytes_minus_one,
    output logic [sdrcb_pkg::LBA_W-1:0]         fis_lba,
    output logic [sdrcb_pkg::FIS_COUNT_W-1:0]   fis_count,
    output logic                                last
);
    import sdrcb_pkg::*;

    // classified command from the front end
    cmd_t front_cmd;
    // command at the head of the queue, consumed entry by entry
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;

    // helpers for the checks below
    logic              out_take;
    logic [TLEN_W-1:0] entry_number;
    logic [IDX_W-1:0]  next_index;

    // front: checks count, finds the lowest free slot, holds slot_count
    sdrcb_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .start_lba        (start_lba),
        .block_count      (block_count),
        .buffer_address   (buffer_address),
        .active_slots     (active_slots),
        .issued_slots     (issued_slots),
        .queue_full       (queue_full),
        .push             (push),
        .cmd              (front_cmd)
    );

    // queue decouples request intake from entry generation
    sdrcb_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // back: one descriptor entry per cycle into the output register, unless out_ready stalls it
    sdrcb_back u_back (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .head_cmd              (head_cmd),
        .empty                 (queue_empty),
        .pop                   (pop),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .status                (status),
        .slot                  (slot),
        .table_length          (table_length),
        .entry_index           (entry_index),
        .entry_address         (entry_address),
        .entry_bytes_minus_one (entry_bytes_minus_one),
        .fis_lba               (fis_lba),
        .fis_count             (fis_count),
        .last                  (last)
    );

    assign out_take     = out_valid && out_ready;
    assign entry_number = TLEN_W'(entry_index) + TLEN_W'(1);
    assign next_index   = entry_index + 1'b1;

    // an error is a single zeroed item
    `SDRCB_ASSERT_SAME(a_err_single, out_valid && status != ST_OK, last && table_length == '0)
    // last marks exactly the final entry of a good command
    `SDRCB_ASSERT_SAME(a_ok_last, out_valid && status == ST_OK, last == (entry_number == table_length))
    // a taken non-final entry is followed at once by the next entry
    `SDRCB_ASSERT_NEXT(a_ok_next, out_take && !last, out_valid && entry_index == $past(next_index))
    // and that entry belongs to the same command slot
    `SDRCB_ASSERT_NEXT(a_ok_same_slot, out_take && !last, slot == $past(slot))
    // the queue never pops while empty
    `SDRCB_ASSERT_SAME(a_no_underflow, pop, !queue_empty)

endmodule
